/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

/* hdl/arst_pkg.sv */
// package: widths, codes and shared types of the address range set table
package arst_pkg;
	localparam int TableEntries = 64;
	localparam int AddrBits = 32;
	localparam int IdxBits = $clog2(TableEntries);
	localparam int CntBits = $clog2(TableEntries + 1);

	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;

	typedef enum logic [1:0] {
		MODE_CONTAINS = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_REMOVE   = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_COVERED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LO_RD,
		S_LO_CHK,
		S_HI_CHK,
		S_HI_RD,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_PUT,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch input word, pointer to zero
		logic hit_chk;   // test the entry read against the queried address
		logic ptr_inc;
		logic ptr_dec;
		logic lo_set;    // lo := hi := ptr
		logic hi_last;   // entry at ptr overlaps, hi := hi + 1
		logic plan;      // register splice plan and status
		logic up_init;   // ptr := used for shifting up
		logic dn_init;   // ptr := hi for shifting down
		logic up_rd;     // read entry below ptr
		logic up_wr;     // write shifted entry at ptr
		logic dn_wr;     // write shifted entry below its old place
		logic put_init;  // ptr := lo for writing new entries
		logic put;       // write one new entry at ptr
		logic commit;    // take the new entry count
		logic out_set;   // load the result word
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_query;
		logic is_empty;
		logic ptr_end;    // ptr >= used
		logic lo_stop;    // end > b
		logic hi_stop;    // begin >= e
		logic no_change;  // plan leaves table alone
		logic grow;       // n > hi-lo
		logic shrink;     // n < hi-lo
		logic up_done;    // ptr == hi
		logic put_done;   // ptr == lo + n
	} sts_t;
endpackage

/* hdl/arst_ram.sv */
// generic single port ram with registered read
module arst_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* hdl/arst_datapath.sv */
// datapath: table memories, scan pointer, splice planning and result word
module arst_datapath import arst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	output sts_t       sts,
	input  logic [1:0] in_mode,
	input  addr_t      in_begin,
	input  addr_t      in_end,
	output logic       res_hit,
	output logic [1:0] res_status,
	output cnt_t       res_count
);
	localparam addr_t TopM1 = {{(AddrBits-1){1'b1}}, 1'b0};
	localparam addr_t One = addr_t'(1);
	localparam cnt_t CntOne = cnt_t'(1);
	localparam cnt_t CntTwo = cnt_t'(2);
	localparam cnt_t CntFull = cnt_t'(TableEntries);

	mode_t   mode_q;
	addr_t   b_q, e_q, q_q;
	cnt_t    used_q, ptr_q, lo_q, hi_q;
	addr_t   fb_q, le_q;
	logic    hit_q;
	status_t status_q;
	cnt_t    n_q, new_used_q;
	addr_t   pab_q, pae_q, pbb_q, pbe_q;

	logic    mem_we;
	idx_t    mem_addr;
	addr_t   wb, we_d, rb, re;

	addr_t   cb, ce;
	cnt_t    span, ptr_m1, dn_dst, put_end;
	logic    ovl, n0, n1, covered, full;
	cnt_t    n_d;
	status_t plan_status;
	addr_t   nb, ne;

	arst_ram #(.Width(AddrBits), .Depth(TableEntries)) u_begin (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(wb), .rdata(rb));
	arst_ram #(.Width(AddrBits), .Depth(TableEntries)) u_end (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(we_d), .rdata(re));

	assign cb = (in_begin < One) ? One : in_begin;
	assign ce = (in_end > TopM1) ? TopM1 : in_end;

	assign span = cnt_t'(hi_q - lo_q);
	assign ovl = span != '0;
	assign ptr_m1 = cnt_t'(ptr_q - CntOne);
	assign dn_dst = cnt_t'(ptr_q - span + n_q);
	assign put_end = cnt_t'(lo_q + n_q);

	// splice plan from the overlapping entries [lo, hi)
	always_comb begin
		nb = (ovl && fb_q < b_q) ? fb_q : b_q;
		ne = (ovl && le_q > e_q) ? le_q : e_q;
		n0 = ovl && fb_q < b_q;
		n1 = ovl && e_q < le_q;
		covered = 1'b0;
		full = 1'b0;
		n_d = '0;
		if (mode_q == MODE_ADD) begin
			covered = span == CntOne && fb_q <= b_q && e_q <= le_q;
			full = !ovl && used_q >= CntFull;
			n_d = CntOne;
		end else begin
			// only a split of a single entry can grow the table
			full = n0 && n1 && span == CntOne && used_q >= CntFull;
			n_d = (n0 && n1) ? CntTwo : ((n0 || n1) ? CntOne : '0);
		end
		plan_status = ST_DONE;
		if (covered) plan_status = ST_COVERED;
		else if (full) plan_status = ST_FULL;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr = ptr_q[IdxBits-1:0];
		wb = rb;
		we_d = re;
		if (ctl.up_rd) mem_addr = ptr_m1[IdxBits-1:0];
		if (ctl.up_wr) mem_we = 1'b1;
		if (ctl.dn_wr) begin
			mem_we = 1'b1;
			mem_addr = dn_dst[IdxBits-1:0];
		end
		if (ctl.put) begin
			mem_we = 1'b1;
			wb = (ptr_q == lo_q) ? pab_q : pbb_q;
			we_d = (ptr_q == lo_q) ? pae_q : pbe_q;
		end
	end

	always_comb begin
		sts = '0;
		sts.is_query = (mode_q == MODE_CONTAINS) || (mode_q == MODE_NONE);
		sts.is_empty = status_q == ST_EMPTY;
		sts.ptr_end = ptr_q >= used_q;
		sts.lo_stop = re > b_q;
		sts.hi_stop = rb >= e_q;
		sts.no_change = (plan_status != ST_DONE) || (mode_q == MODE_REMOVE && !ovl);
		sts.grow = n_d > span;
		sts.shrink = n_d < span;
		sts.up_done = ptr_q == hi_q;
		sts.put_done = ptr_q == put_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ptr_q <= '0;
			hit_q <= 1'b0;
			status_q <= ST_DONE;
			res_hit <= 1'b0;
			res_status <= ST_DONE;
			res_count <= '0;
		end else begin
			if (ctl.load) begin
				hit_q <= 1'b0;
				status_q <= (cb >= ce && (in_mode == MODE_ADD || in_mode == MODE_REMOVE))
					? ST_EMPTY : ST_DONE;
			end
			if (ctl.hit_chk && mode_q == MODE_CONTAINS && rb <= q_q && q_q < re)
				hit_q <= 1'b1;
			if (ctl.plan) status_q <= plan_status;
			if (ctl.load) ptr_q <= '0;
			else if (ctl.ptr_inc) ptr_q <= cnt_t'(ptr_q + CntOne);
			else if (ctl.ptr_dec) ptr_q <= ptr_m1;
			else if (ctl.up_init) ptr_q <= used_q;
			else if (ctl.dn_init) ptr_q <= hi_q;
			else if (ctl.put_init) ptr_q <= lo_q;
			if (ctl.commit) used_q <= new_used_q;
			if (ctl.out_set) begin
				res_hit <= hit_q;
				res_status <= status_q;
				res_count <= used_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= mode_t'(in_mode);
			b_q <= cb;
			e_q <= ce;
			q_q <= in_begin;
		end
		if (ctl.lo_set) begin
			lo_q <= ptr_q;
			hi_q <= ptr_q;
			fb_q <= rb;
		end
		if (ctl.hi_last) begin
			hi_q <= cnt_t'(hi_q + CntOne);
			le_q <= re;
		end
		if (ctl.plan) begin
			n_q <= n_d;
			new_used_q <= cnt_t'(used_q + n_d - span);
			if (mode_q == MODE_ADD) begin
				pab_q <= nb;
				pae_q <= ne;
			end else if (n0) begin
				pab_q <= fb_q;
				pae_q <= b_q;
			end else begin
				pab_q <= e_q;
				pae_q <= le_q;
			end
			pbb_q <= e_q;
			pbe_q <= le_q;
		end
	end
endmodule

/* hdl/arst_ctrl.sv */
// controller state machine for scan, shift and write back
module arst_ctrl import arst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);
	state_t state_q, state_d;
	logic   full_q;
	logic   out_take;

	// the result word may only be loaded once the held word has left
	assign out_take = (state_q == S_OUT) && (!full_q || out_ready);
	assign in_ready = state_q == S_IDLE;
	assign out_valid = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_take) full_q <= 1'b1;
			else if (out_ready) full_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_LO_RD;
			S_LO_RD:  begin
				if (!sts.is_query && sts.is_empty) state_d = S_OUT;
				else if (sts.ptr_end) state_d = sts.is_query ? S_OUT : S_DECIDE;
				else state_d = S_LO_CHK;
			end
			S_LO_CHK: state_d = (!sts.is_query && sts.lo_stop) ? S_HI_CHK : S_LO_RD;
			S_HI_CHK: state_d = sts.hi_stop ? S_DECIDE : S_HI_RD;
			S_HI_RD:  state_d = sts.ptr_end ? S_DECIDE : S_HI_CHK;
			S_DECIDE: begin
				if (sts.no_change) state_d = S_OUT;
				else if (sts.grow) state_d = S_UP_RD;
				else if (sts.shrink) state_d = S_DN_RD;
				else state_d = S_PUT;
			end
			S_UP_RD:  state_d = sts.up_done ? S_PUT : S_UP_WR;
			S_UP_WR:  state_d = S_UP_RD;
			S_DN_RD:  state_d = sts.ptr_end ? S_PUT : S_DN_WR;
			S_DN_WR:  state_d = S_DN_RD;
			S_PUT:    if (sts.put_done) state_d = S_OUT;
			S_OUT:    if (out_take) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE:   ctl.load = in_valid;
			S_LO_RD:  ctl.lo_set = sts.ptr_end && !sts.is_query && !sts.is_empty;
			S_LO_CHK: begin
				ctl.hit_chk = sts.is_query;
				if (!sts.is_query && sts.lo_stop) ctl.lo_set = 1'b1;
				else ctl.ptr_inc = 1'b1;
			end
			S_HI_CHK: if (!sts.hi_stop) begin
				ctl.hi_last = 1'b1;
				ctl.ptr_inc = 1'b1;
			end
			S_HI_RD:  ctl = '0;
			S_DECIDE: begin
				ctl.plan = 1'b1;
				if (!sts.no_change) begin
					if (sts.grow) ctl.up_init = 1'b1;
					else if (sts.shrink) ctl.dn_init = 1'b1;
					else ctl.put_init = 1'b1;
				end
			end
			S_UP_RD:  if (sts.up_done) ctl.put_init = 1'b1; else ctl.up_rd = 1'b1;
			S_UP_WR:  begin
				ctl.up_wr = 1'b1;
				ctl.ptr_dec = 1'b1;
			end
			S_DN_RD:  ctl.put_init = sts.ptr_end;
			S_DN_WR:  begin
				ctl.dn_wr = 1'b1;
				ctl.ptr_inc = 1'b1;
			end
			S_PUT:    if (sts.put_done) ctl.commit = 1'b1; else begin
				ctl.put = 1'b1;
				ctl.ptr_inc = 1'b1;
			end
			S_OUT:    ctl.out_set = out_take;
			default:  ctl = '0;
		endcase
	end
endmodule

/* hdl/address_range_set_table.sv */
// top level of the address range set table
// keeps up to 64 sorted, disjoint half-open address ranges in single port memories
// input channel: mode, range_begin, range_end with in_valid/in_ready
//   mode 0 tests whether range_begin lies in a stored range, mode 1 adds a range,
//   merging every overlapping entry, mode 2 removes one, trimming, deleting or splitting
// output channel: hit, status, entry_count with out_valid/out_ready, one word per word in
// status: 0 done, 1 already covered, 2 empty range, 3 table full
// a contains word scans every entry, an empty add or remove goes straight to the result,
//   any other add or remove scans and, if the table changes, shifts the tail as needed
//   and writes back the new entries
// throughput: one word at a time, the next word is taken in the cycle after the result
//   is loaded; each shifted entry is read, then written, in the single port memories
// reset clears the entry count and the output register; no entry is read before it
//   is written, so the table needs no clearing pass
// a stalled output word is held unchanged; the next word is taken and processed,
//   and its result waits until the held word has left
module address_range_set_table import arst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  addr_t       range_begin,
	input  addr_t       range_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [1:0]  status,
	output logic [6:0]  entry_count
);
	`include "assert_macros.svh"

	ctl_t ctl;
	sts_t sts;
	cnt_t count;

	arst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl));

	arst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .in_mode(mode),
		.in_begin(range_begin), .in_end(range_end), .res_hit(hit),
		.res_status(status), .res_count(count));

	assign entry_count = 7'(count);

	`ASSERT_IMPL(a_count_max, count <= cnt_t'(TableEntries))
	`ASSERT_NEXT(a_take_one, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(status) && $stable(entry_count))
endmodule

/* tb/tb_address_range_set_table.sv */
// testbench for the address range set table: scoreboard class, stimulus and checks
module tb_address_range_set_table import arst_pkg::*;;

	class range_scoreboard;
		logic [31:0] tab_b[$];
		logic [31:0] tab_e[$];
		logic       exp_hit[$];
		logic [1:0] exp_status[$];
		logic [6:0] exp_count[$];
		int mismatches;

		function void reset_table();
			tab_b.delete();
			tab_e.delete();
			mismatches = 0;
		endfunction

		// work out the result of one accepted word and update the table copy
		function void note_word(logic [1:0] md, logic [31:0] rb, logic [31:0] re);
			logic h;
			logic [1:0] st;
			logic [31:0] b, e, nb, ne;
			logic [31:0] pb[2];
			logic [31:0] pe[2];
			int lo, hi, n, used;
			h = 0;
			st = ST_DONE;
			b = rb;
			e = re;
			used = tab_b.size();
			if (md == MODE_CONTAINS) begin
				for (int i = 0; i < used; i++)
					if (tab_b[i] <= b && b < tab_e[i]) h = 1;
			end else if (md == MODE_ADD || md == MODE_REMOVE) begin
				if (b < 1) b = 1;
				if (e > 32'hFFFF_FFFE) e = 32'hFFFF_FFFE;
				if (b >= e) begin
					st = ST_EMPTY;
				end else begin
					lo = 0;
					while (lo < used && tab_e[lo] <= b) lo++;
					hi = lo;
					while (hi < used && tab_b[hi] < e) hi++;
					if (md == MODE_ADD) begin
						if (hi - lo == 1 && tab_b[lo] <= b && e <= tab_e[lo]) begin
							st = ST_COVERED;
						end else if (hi == lo && used >= TableEntries) begin
							st = ST_FULL;
						end else begin
							nb = b;
							ne = e;
							if (hi > lo) begin
								if (tab_b[lo] < nb) nb = tab_b[lo];
								if (tab_e[hi-1] > ne) ne = tab_e[hi-1];
							end
							for (int i = lo; i < hi; i++) begin
								tab_b.delete(lo);
								tab_e.delete(lo);
							end
							tab_b.insert(lo, nb);
							tab_e.insert(lo, ne);
						end
					end else if (hi > lo) begin
						n = 0;
						if (tab_b[lo] < b) begin
							pb[n] = tab_b[lo];
							pe[n] = b;
							n++;
						end
						if (e < tab_e[hi-1]) begin
							pb[n] = e;
							pe[n] = tab_e[hi-1];
							n++;
						end
						if (n > hi - lo && used + n - (hi - lo) > TableEntries) begin
							st = ST_FULL;
						end else begin
							for (int i = lo; i < hi; i++) begin
								tab_b.delete(lo);
								tab_e.delete(lo);
							end
							for (int i = n - 1; i >= 0; i--) begin
								tab_b.insert(lo, pb[i]);
								tab_e.insert(lo, pe[i]);
							end
						end
					end
				end
			end
			exp_hit.push_back(h);
			exp_status.push_back(st);
			exp_count.push_back(7'(tab_b.size()));
		endfunction

		function void check_word(logic h, logic [1:0] st, logic [6:0] cnt);
			logic eh;
			logic [1:0] es;
			logic [6:0] ec;
			if (exp_hit.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word: hit %0d status %0d count %0d", h, st, cnt);
				return;
			end
			eh = exp_hit.pop_front();
			es = exp_status.pop_front();
			ec = exp_count.pop_front();
			if (h !== eh || st !== es || cnt !== ec) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: expected hit %0d status %0d count %0d, got %0d %0d %0d",
						eh, es, ec, h, st, cnt);
			end
		endfunction

		function int pending();
			return exp_hit.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [31:0] range_begin;
	logic [31:0] range_end;
	logic        out_valid;
	logic        out_ready;
	logic        hit;
	logic [1:0]  status;
	logic [6:0]  entry_count;

	range_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;

	address_range_set_table i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .range_begin(range_begin), .range_end(range_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .status(status), .entry_count(entry_count)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// receiver side: random stalls, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(hit, status, entry_count);
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid drops only while the sender idles, so each falling edge sees one update
	task automatic send_word(logic [1:0] md, logic [31:0] rb, logic [31:0] re);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		mode <= md;
		range_begin <= rb;
		range_end <= re;
		do @(posedge clk); while (!in_ready);
		sb.note_word(md, rb, re);
		@(negedge clk);
	endtask

	// addresses mostly in a small window so ranges meet and overlap
	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 85) return 32'($urandom_range(2000));
		if (r < 90) return 32'hFFFF_FFFF - 32'($urandom_range(3));
		return $urandom();
	endfunction

	task automatic random_word();
		logic [1:0] md;
		logic [31:0] b, e;
		int r;
		r = $urandom_range(99);
		md = (r < 30) ? MODE_CONTAINS : (r < 65) ? MODE_ADD : (r < 97) ? MODE_REMOVE : MODE_NONE;
		b = pick_addr();
		if ($urandom_range(9) < 8) e = b + 32'($urandom_range(1, 60));
		else e = pick_addr();
		send_word(md, b, e);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		sb = new();
		sb.reset_table();
		arst_n = 0;
		in_valid = 0;
		mode = MODE_CONTAINS;
		range_begin = 0;
		range_end = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes and each special case
		send_word(MODE_CONTAINS, 32'd0, 32'd0);
		send_word(MODE_ADD, 32'd0, 32'hFFFF_FFFF);
		send_word(MODE_CONTAINS, 32'd0, 32'd0);
		send_word(MODE_CONTAINS, 32'hFFFF_FFFE, 32'd0);
		send_word(MODE_CONTAINS, 32'hFFFF_FFFD, 32'd0);
		send_word(MODE_ADD, 32'd5, 32'd9);
		send_word(MODE_REMOVE, 32'd100, 32'd200);
		send_word(MODE_REMOVE, 32'd0, 32'hFFFF_FFFF);
		send_word(MODE_ADD, 32'd10, 32'd20);
		send_word(MODE_ADD, 32'd20, 32'd30);
		send_word(MODE_ADD, 32'd12, 32'd15);
		send_word(MODE_ADD, 32'd15, 32'd25);
		send_word(MODE_ADD, 32'd7, 32'd7);
		send_word(MODE_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_word(MODE_REMOVE, 32'd40, 32'd3);
		send_word(MODE_REMOVE, 32'd12, 32'd14);
		send_word(MODE_NONE, 32'hAAAA_5555, 32'h5555_AAAA);
		send_word(MODE_CONTAINS, 32'd30, 32'hFFFF_FFFF);
		send_word(MODE_CONTAINS, 32'd10, 32'd0);
		// fill the table, then hit full on add and on split
		for (int i = 0; i < 70; i++)
			send_word(MODE_ADD, 32'(1000 + 4 * i), 32'(1002 + 4 * i));
		send_word(MODE_REMOVE, 32'd20, 32'd21);
		send_word(MODE_REMOVE, 32'd1000, 32'd1001);
		send_word(MODE_REMOVE, 32'd1008, 32'd1010);
		send_word(MODE_REMOVE, 32'd1008, 32'd1009);
		send_word(MODE_REMOVE, 32'd0, 32'hFFFF_FFFF);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 56 : 0;
			recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 11 : 0;
			for (int i = 0; i < 185; i++) begin
				if (i == 100) wait_drained();
				random_word();
			end
		end

		recv_idle_pct = 0;
		wait_drained();
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* address_range_set_table.f */
+incdir+hdl
hdl/arst_pkg.sv
hdl/arst_ram.sv
hdl/arst_datapath.sv
hdl/arst_ctrl.sv
hdl/address_range_set_table.sv
tb/tb_address_range_set_table.sv
